// ----- rtl/gcs_pkg.sv -----
// Shared types and constants for the guest clock scaler.
package gcs_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int DIV_STEP_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_NUMERATOR   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_DENOMINATOR = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GUEST_FREQ        = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SYS_EPOCH         = 8'd3;

  localparam logic [63:0] TIME_UNITS_PER_SECOND = 64'd10000000;

  // Offsets at or above this value give an uptime beyond 32 bits.
  localparam logic [87:0] MILLIS_LIMIT = 88'd42949672960000;

  // 2^60 / 10000 rounded up. Multiplying an offset below the limit by this and
  // keeping bits 91:60 gives the exact millisecond count.
  localparam logic [63:0] MILLIS_RECIP = 64'd115292150460685;

  // Quotient bits produced by each division pass.
  localparam logic [DIV_STEP_W-1:0] STEPS_RATIO  = 8'd128;
  localparam logic [DIV_STEP_W-1:0] STEPS_OFFSET = 8'd88;

  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
  } div_ctl_t;

endpackage

// ----- rtl/gcs_mul.sv -----
// Sequential 64 by 64 multiplier built from four 32 by 32 partial products.
module gcs_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] product
);

  logic         busy;
  logic [2:0]   idx;
  logic [63:0]  prod_r;
  logic [1:0]   sh_r;
  logic [127:0] acc;
  logic [31:0]  a_h;
  logic [31:0]  b_h;

  assign a_h     = idx[0] ? a[63:32] : a[31:0];
  assign b_h     = idx[1] ? b[63:32] : b[31:0];
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= 3'd0;
      end else if (busy) begin
        idx <= idx + 3'd1;
        if (idx == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The partial product of one step is added into the sum on the next.
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= 128'd0;
    end else if (busy) begin
      if (idx != 3'd4) begin
        prod_r <= a_h * b_h;
        sh_r   <= {1'b0, idx[0]} + {1'b0, idx[1]};
      end
      if (idx != 3'd0) begin
        acc <= acc + ({64'd0, prod_r} << {sh_r, 5'd0});
      end
    end
  end

endmodule

// ----- rtl/gcs_div.sv -----
// Restoring divider of a 128-bit dividend by a 64-bit divisor, one bit per cycle.
module gcs_div (
  input  logic              clk,
  input  logic              rst,
  input  gcs_pkg::div_ctl_t ctl,
  input  logic [127:0]      dividend,
  input  logic [63:0]       divisor,
  output logic              done,
  output logic [127:0]      quotient
);

  logic                           busy;
  logic [gcs_pkg::DIV_STEP_W-1:0] count;
  logic [127:0]                   dvd;
  logic [63:0]                    rem;
  logic [64:0]                    rem_sh;
  logic [64:0]                    diff;
  logic                           ge;

  // The dividend is loaded left aligned, so after the pass its register holds
  // the quotient in the low bits and zeros above.
  assign rem_sh   = {rem, dvd[127]};
  assign diff     = rem_sh - {1'b0, divisor};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        count <= ctl.steps;
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == 8'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd <= dividend;
      rem <= 64'd0;
    end else if (busy) begin
      dvd <= {dvd[126:0], ge};
      rem <= ge ? diff[63:0] : rem_sh[63:0];
    end
  end

endmodule

// ----- rtl/guest_clock_scaler.sv -----
// Top level of the guest clock scaler: sequencer, state and stream ports.
//
// Each host tick sample passes from its request through S_MUL1, S_DIV1,
// S_MUL2, S_DIV2 and S_MUL3 to S_FINISH, where its result is offered, and
// the next request can be taken in the cycle after that, so the block works
// on one sample at a time. The time goes to three passes of the four-step
// multiplier (ratio product, tick count times 10^7, and a reciprocal multiply
// for milliseconds) and two passes of the one-bit-per-cycle divider (the
// 128-bit ratio division and the 88-bit conversion to 100ns units), plus the
// load of the result. s_tready is high only while the sequencer is idle; a
// finished result waits in the output register, so the next request is taken
// while it is still pending, and the sequencer holds its new result until the
// register is free. The first sample after reset only primes the stored host
// tick, and a backward step adds no ticks.
module guest_clock_scaler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [63:0]                   s_tdata,   // host_ticks[63:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // guest_ticks[63:0], guest_system_time[127:64], uptime_millis[159:128]
  output logic [159:0]                  m_tdata
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MUL1   = 7'b0000010,
    S_DIV1   = 7'b0000100,
    S_MUL2   = 7'b0001000,
    S_DIV2   = 7'b0010000,
    S_MUL3   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state;

  logic [63:0] ratio_numerator;
  logic [63:0] ratio_denominator;
  logic [63:0] guest_freq;
  logic [63:0] sys_epoch;

  logic [63:0] last_host_tick;
  logic [63:0] guest_ticks;
  logic        primed;
  logic [63:0] delta;
  logic [87:0] offset;
  logic        sat;

  logic        mul_kick;
  logic        div_kick;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic        mul_done;
  logic [127:0] mul_product;

  gcs_pkg::div_ctl_t div_ctl;
  logic [127:0]      div_dividend;
  logic [63:0]       div_divisor;
  logic              div_done;
  logic [127:0]      div_quo;

  logic        in_fire;
  logic        out_load;
  logic [63:0] den_eff;
  logic [63:0] freq_eff;
  logic [31:0] millis;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign out_load  = (state == S_FINISH) && (!m_tvalid || m_tready);

  assign den_eff  = (ratio_denominator == 64'd0) ? 64'd1 : ratio_denominator;
  assign freq_eff = (guest_freq == 64'd0) ? 64'd1 : guest_freq;
  assign millis   = sat ? 32'hFFFF_FFFF : mul_product[91:60];

  // Unit operands follow the state and stay steady through each pass.
  always_comb begin
    mul_a        = delta;
    mul_b        = ratio_numerator;
    div_dividend = mul_product;
    div_divisor  = den_eff;
    div_ctl.steps = gcs_pkg::STEPS_RATIO;
    unique case (state)
      S_MUL2: begin
        mul_a = guest_ticks;
        mul_b = gcs_pkg::TIME_UNITS_PER_SECOND;
      end
      S_DIV2: begin
        div_dividend  = {mul_product[87:0], 40'd0};
        div_divisor   = freq_eff;
        div_ctl.steps = gcs_pkg::STEPS_OFFSET;
      end
      S_MUL3: begin
        mul_a = {18'd0, offset[45:0]};
        mul_b = gcs_pkg::MILLIS_RECIP;
      end
      default: begin
      end
    endcase
    div_ctl.start = div_kick;
  end

  gcs_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_kick),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_product)
  );

  gcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_numerator   <= 64'd1;
      ratio_denominator <= 64'd1;
      guest_freq        <= 64'd10000000;
      sys_epoch         <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == gcs_pkg::REG_RATIO_NUMERATOR) begin
        ratio_numerator <= cfg_data;
      end
      if (cfg_index == gcs_pkg::REG_RATIO_DENOMINATOR) begin
        ratio_denominator <= cfg_data;
      end
      if (cfg_index == gcs_pkg::REG_GUEST_FREQ) begin
        guest_freq <= cfg_data;
      end
      if (cfg_index == gcs_pkg::REG_SYS_EPOCH) begin
        sys_epoch <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      last_host_tick <= 64'd0;
      guest_ticks    <= 64'd0;
      primed         <= 1'b0;
      mul_kick       <= 1'b0;
      div_kick       <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      mul_kick <= in_fire || (((state == S_DIV1) || (state == S_DIV2)) && div_done);
      div_kick <= ((state == S_MUL1) || (state == S_MUL2)) && mul_done;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            state          <= S_MUL1;
            last_host_tick <= s_tdata;
            primed         <= 1'b1;
          end
        end
        S_MUL1: begin
          if (mul_done) begin
            state <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            state       <= S_MUL2;
            guest_ticks <= guest_ticks + div_quo[63:0];
          end
        end
        S_MUL2: begin
          if (mul_done) begin
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            state <= S_MUL3;
          end
        end
        S_MUL3: begin
          if (mul_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      delta <= (primed && (s_tdata > last_host_tick)) ? (s_tdata - last_host_tick) : 64'd0;
    end
    if ((state == S_DIV2) && div_done) begin
      offset <= div_quo[87:0];
      sat    <= (div_quo[87:0] >= gcs_pkg::MILLIS_LIMIT);
    end
    if (out_load) begin
      m_tdata <= {millis, sys_epoch + offset[63:0], guest_ticks};
    end
  end

  a_one_kick: assert property (@(posedge clk) disable iff (rst)
    !(mul_kick && div_kick))
    else $error("multiplier and divider started together");

  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_MUL1 || state == S_MUL2 || state == S_MUL3))
    else $error("multiplier finished outside a multiply state");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV1 || state == S_DIV2))
    else $error("divider finished outside a divide state");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == S_MUL1 && mul_kick && primed))
    else $error("accepted request did not start the multiplier");

  a_load_on_free: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid)
    else $error("result load did not raise m_tvalid");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for guest_clock_scaler: directed table, then random config phases.
`timescale 1ns / 1ps

module tb;

  localparam logic [63:0] ALL_ONES = '1;

  // Field order matches m_tdata, lowest bits last.
  typedef struct packed {
    logic [31:0] uptime;
    logic [63:0] sys_time;
    logic [63:0] ticks;
  } guest_time_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [gcs_pkg::CFG_IDX_W-1:0] index;
    logic [63:0]                   value;
    logic                          typed;
    guest_time_t                   want;
  } row_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [gcs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0]                   cfg_data;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [63:0]                   s_tdata;   // host_ticks[63:0]
  logic                          m_tvalid;
  logic                          m_tready;
  // guest_ticks[63:0], guest_system_time[127:64], uptime_millis[159:128]
  logic [159:0]                  m_tdata;

  // Shadow of the block's registers and state.
  logic [63:0] ratio_num = 64'd1;
  logic [63:0] ratio_den = 64'd1;
  logic [63:0] tick_freq = 64'd10000000;
  logic [63:0] sys_epoch = 64'd0;
  logic [63:0] last_host = 64'd0;
  logic [63:0] guest_ticks = 64'd0;
  logic        primed = 1'b0;

  guest_time_t guest_times_due[$];
  int          failures = 0;
  int          results_seen = 0;
  int          burst_left = 0;

  // The first rows run on reset settings, so their results are typed in directly.
  row_t plan [32] = '{
    '{ROW_SAMPLE, '0, 64'd1193046, 1'b1, '{32'd0, 64'd0, 64'd0}},
    '{ROW_SAMPLE, '0, 64'd1193046, 1'b1, '{32'd0, 64'd0, 64'd0}},
    '{ROW_SAMPLE, '0, 64'd11193046, 1'b1, '{32'd1000, 64'd10000000, 64'd10000000}},
    '{ROW_SAMPLE, '0, 64'd0, 1'b1, '{32'd1000, 64'd10000000, 64'd10000000}},
    '{ROW_SAMPLE, '0, ALL_ONES, 1'b0, '0},
    '{ROW_SAMPLE, '0, ALL_ONES, 1'b0, '0},
    '{ROW_SAMPLE, '0, 64'd0, 1'b0, '0},
    '{ROW_CFG, gcs_pkg::REG_RATIO_NUMERATOR, ALL_ONES, 1'b0, '0},
    '{ROW_CFG, gcs_pkg::REG_RATIO_DENOMINATOR, 64'd1, 1'b0, '0},
    '{ROW_SAMPLE, '0, 64'd1, 1'b0, '0},
    '{ROW_SAMPLE, '0, ALL_ONES, 1'b0, '0},
    '{ROW_CFG, gcs_pkg::REG_RATIO_DENOMINATOR, ALL_ONES, 1'b0, '0},
    '{ROW_SAMPLE, '0, 64'd0, 1'b0, '0},
    '{ROW_SAMPLE, '0, ALL_ONES, 1'b0, '0},
    '{ROW_CFG, gcs_pkg::REG_RATIO_DENOMINATOR, 64'd0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 64'd0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 64'd5, 1'b0, '0},
    '{ROW_CFG, gcs_pkg::REG_RATIO_NUMERATOR, 64'd7, 1'b0, '0},
    '{ROW_CFG, gcs_pkg::REG_RATIO_DENOMINATOR, 64'd3, 1'b0, '0},
    '{ROW_CFG, gcs_pkg::REG_GUEST_FREQ, 64'd0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 64'd0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 64'd100, 1'b0, '0},
    '{ROW_CFG, gcs_pkg::REG_GUEST_FREQ, ALL_ONES, 1'b0, '0},
    '{ROW_CFG, gcs_pkg::REG_SYS_EPOCH, ALL_ONES, 1'b0, '0},
    '{ROW_SAMPLE, '0, 64'd0, 1'b0, '0},
    '{ROW_SAMPLE, '0, ALL_ONES, 1'b0, '0},
    '{ROW_CFG, gcs_pkg::REG_GUEST_FREQ, 64'd1, 1'b0, '0},
    '{ROW_CFG, gcs_pkg::REG_SYS_EPOCH, 64'd0, 1'b0, '0},
    '{ROW_CFG, gcs_pkg::REG_RATIO_NUMERATOR, 64'd1, 1'b0, '0},
    '{ROW_CFG, gcs_pkg::REG_RATIO_DENOMINATOR, 64'd1, 1'b0, '0},
    '{ROW_SAMPLE, '0, 64'd0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 64'd1000, 1'b0, '0}
  };

  guest_clock_scaler DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("FAIL guest_clock_scaler");
    $finish;
  end

  // Advances the shadow state by one host sample and returns the guest time it yields.
  function automatic guest_time_t scale_host_sample(input logic [63:0] host);
    logic [63:0]  delta;
    logic [63:0]  den;
    logic [63:0]  freq;
    logic [127:0] scaled;
    logic [127:0] offset;
    logic [127:0] millis;
    guest_time_t  r;
    den  = (ratio_den == 64'd0) ? 64'd1 : ratio_den;
    freq = (tick_freq == 64'd0) ? 64'd1 : tick_freq;
    if (primed) begin
      delta = (host > last_host) ? host - last_host : 64'd0;
      scaled = ({64'd0, delta} * {64'd0, ratio_num}) / {64'd0, den};
      guest_ticks = guest_ticks + scaled[63:0];
    end
    primed = 1'b1;
    last_host = host;
    offset = ({64'd0, guest_ticks} * {64'd0, gcs_pkg::TIME_UNITS_PER_SECOND})
             / {64'd0, freq};
    millis = offset / 128'd10000;
    r.ticks    = guest_ticks;
    r.sys_time = sys_epoch + offset[63:0];
    r.uptime   = (millis > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : millis[31:0];
    return r;
  endfunction

  function automatic logic [63:0] pick_ratio_term();
    case ($urandom_range(0, 5))
      0: return 64'd1;
      1: return 64'($urandom_range(1, 1000));
      2: return 64'($urandom_range(1, 32'hFFFF_FFFF));
      3: return {$urandom, $urandom};
      4: return ALL_ONES;
      default: return 64'($urandom_range(1, 50)) * 64'd1000;
    endcase
  endfunction

  task automatic send_sample(input logic [63:0] host, input logic typed,
                             input guest_time_t want);
    int          gap;
    guest_time_t pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= host;
    do @(posedge clk); while (!s_tready);
    pred = scale_host_sample(host);
    guest_times_due.push_back(typed ? want : pred);
  endtask

  // Registers change only once every pending request has produced its result.
  task automatic write_reg(input logic [gcs_pkg::CFG_IDX_W-1:0] index,
                           input logic [63:0] data);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (guest_times_due.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      gcs_pkg::REG_RATIO_NUMERATOR:   ratio_num = data;
      gcs_pkg::REG_RATIO_DENOMINATOR: ratio_den = data;
      gcs_pkg::REG_GUEST_FREQ:        tick_freq = data;
      gcs_pkg::REG_SYS_EPOCH:         sys_epoch = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    guest_time_t got;
    guest_time_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      results_seen++;
      if (guest_times_due.size() == 0) begin
        $error("result with no request pending: %h", m_tdata);
        failures++;
      end else begin
        want = guest_times_due.pop_front();
        if (got.ticks !== want.ticks) begin
          $error("guest_ticks: expected %h, got %h", want.ticks, got.ticks);
          failures++;
        end
        if (got.sys_time !== want.sys_time) begin
          $error("guest_system_time: expected %h, got %h", want.sys_time, got.sys_time);
          failures++;
        end
        if (got.uptime !== want.uptime) begin
          $error("uptime_millis: expected %h, got %h", want.uptime, got.uptime);
          failures++;
        end
      end
    end
  end

  // Result side: random stall patterns, plus one long hold-off that backs up the input.
  initial begin
    int mode;
    int span;
    bit held;
    held = 1'b0;
    m_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (!held && results_seen >= 40) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (3000) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(1, 400);
      repeat (span) begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 7) == 0);
          default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin
    logic [63:0] host;
    logic [63:0] pick;
    int          waited;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_reg(plan[i].index, plan[i].value);
      else send_sample(plan[i].value, plan[i].typed, plan[i].want);
    end

    host = 64'd1000;
    for (int phase = 0; phase < 14; phase++) begin
      write_reg(gcs_pkg::REG_RATIO_NUMERATOR, pick_ratio_term());
      write_reg(gcs_pkg::REG_RATIO_DENOMINATOR, pick_ratio_term());
      case ($urandom_range(0, 5))
        0: pick = 64'd10000000;
        1: pick = 64'd1;
        2: pick = {$urandom, $urandom};
        3: pick = 64'($urandom_range(1000, 100000000));
        4: pick = ALL_ONES;
        default: pick = 64'($urandom);
      endcase
      write_reg(gcs_pkg::REG_GUEST_FREQ, pick);
      case ($urandom_range(0, 3))
        0: pick = 64'd0;
        1: pick = ALL_ONES;
        default: pick = {$urandom, $urandom};
      endcase
      write_reg(gcs_pkg::REG_SYS_EPOCH, pick);
      // Mostly a counter moving forward, with some repeats, steps back and jumps.
      repeat (100) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: host = host + 64'($urandom_range(1, 100000));
          6: host = host + {$urandom, $urandom};
          7: ;
          8: host = host - 64'($urandom_range(1, 5000));
          default: host = {$urandom, $urandom};
        endcase
        send_sample(host, 1'b0, '0);
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    waited = 0;
    while (guest_times_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    if (guest_times_due.size() != 0) begin
      $error("%0d expected results never arrived", guest_times_due.size());
      failures++;
    end
    if (failures == 0) begin
      $display("PASS guest_clock_scaler");
    end else begin
      $display("FAIL guest_clock_scaler");
    end
    $finish;
  end

endmodule
